>>> rtl/core/pcc_pkg.sv
package pcc_pkg;

    typedef enum logic [1:0] {
        FMT_RGB888 = 2'd0,
        FMT_BGR555 = 2'd1,
        FMT_YUV888 = 2'd2
    } fmt_t;

    typedef struct packed {
        logic [7:0] b2;
        logic [7:0] b1;
        logic [7:0] b0;
    } pix_t;

    typedef struct packed {
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
    } rgb_t;

    typedef struct packed {
        logic [7:0] v;
        logic [7:0] u;
        logic [7:0] y;
    } yuv_t;

    typedef struct packed {
        logic same;
        yuv_t yuv;
        rgb_t rgb;
    } info_t;

    localparam int SQ_W          = 18;
    localparam int ROOT_W        = 9;
    localparam int ISQRT_STAGES  = 3;
    localparam int ISQRT_STEPS   = 3;

    // Expands a 5-bit channel to floor(c * 255 / 31) as 8c + floor(7c / 31).
    function automatic logic [7:0] scale5(input logic [4:0] c);
        logic [7:0]  x7;
        logic [16:0] p;
        x7 = {3'b000, c} * 8'd7;
        p  = {9'b0, x7} * 17'd265;
        return {c, 3'b000} + {5'b00000, p[15:13]};
    endfunction

    // Drops the fraction and clamps a fixed-point sum to 0..255.
    function automatic logic [7:0] settle(input logic signed [31:0] acc, input int frac);
        logic signed [31:0] t;
        t = acc >>> frac;
        if (acc < 0) begin
            return 8'd0;
        end else if (t > 32'sd255) begin
            return 8'hFF;
        end else begin
            return t[7:0];
        end
    endfunction

endpackage

>>> rtl/core/pcc_decode.sv
module pcc_decode #(
    parameter int COEF_FRACTION_BITS = 12
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  pcc_pkg::fmt_t  fmt,
    input  logic           in_valid,
    output logic           in_ready,
    input  pcc_pkg::pix_t  in_pix_a,
    input  pcc_pkg::pix_t  in_pix_b,
    output logic           out_valid,
    input  logic           out_ready,
    output pcc_pkg::rgb_t  out_rgb_a,
    output pcc_pkg::rgb_t  out_rgb_b
);
    import pcc_pkg::*;

    localparam int F     = COEF_FRACTION_BITS;
    localparam int ONE   = 1 << F;
    localparam int KW    = F + 2;
    localparam int ACC_W = F + 11;

    localparam logic signed [KW-1:0] K_RV = KW'((14075 * ONE + 5000) / 10000);
    localparam logic signed [KW-1:0] K_GU = KW'((3455 * ONE + 5000) / 10000);
    localparam logic signed [KW-1:0] K_GV = KW'((7169 * ONE + 5000) / 10000);
    localparam logic signed [KW-1:0] K_BU = KW'((17790 * ONE + 5000) / 10000);

    typedef struct packed {
        rgb_t                    direct;
        logic [7:0]              y;
        logic signed [ACC_W-1:0] p_rv;
        logic signed [ACC_W-1:0] p_gu;
        logic signed [ACC_W-1:0] p_gv;
        logic signed [ACC_W-1:0] p_bu;
    } dec_t;

    dec_t a_next [2];
    dec_t a_reg  [2];
    rgb_t b_next [2];
    rgb_t b_reg  [2];
    logic is_yuv_reg;
    logic a_valid_reg, b_valid_reg;
    logic a_ready, b_ready;

    function automatic dec_t front(input pix_t px, input fmt_t f);
        dec_t d;
        logic signed [ACC_W-1:0] u;
        logic signed [ACC_W-1:0] v;
        u = $signed({{(ACC_W-8){1'b0}}, px.b1}) - $signed(ACC_W'(128));
        v = $signed({{(ACC_W-8){1'b0}}, px.b2}) - $signed(ACC_W'(128));
        d.y    = px.b0;
        d.p_rv = ACC_W'(K_RV) * v;
        d.p_gu = ACC_W'(K_GU) * u;
        d.p_gv = ACC_W'(K_GV) * v;
        d.p_bu = ACC_W'(K_BU) * u;
        case (f)
            FMT_RGB888: begin
                d.direct.r = px.b0;
                d.direct.g = px.b1;
                d.direct.b = px.b2;
            end
            FMT_BGR555: begin
                d.direct.b = scale5(px.b1[6:2]);
                d.direct.g = scale5({px.b1[1:0], px.b0[7:5]});
                d.direct.r = scale5(px.b0[4:0]);
            end
            default: begin
                d.direct = '0;
            end
        endcase
        return d;
    endfunction

    function automatic rgb_t back(input dec_t d);
        rgb_t c;
        logic signed [ACC_W-1:0] ys;
        ys  = $signed({{(ACC_W-8){1'b0}}, d.y}) <<< F;
        c.r = settle(32'(ys + d.p_rv), F);
        c.g = settle(32'(ys - d.p_gu - d.p_gv), F);
        c.b = settle(32'(ys + d.p_bu), F);
        return c;
    endfunction

    always_comb begin
        a_next[0] = front(in_pix_a, fmt);
        a_next[1] = front(in_pix_b, fmt);
        for (int i = 0; i < 2; i++) begin
            b_next[i] = is_yuv_reg ? back(a_reg[i]) : a_reg[i].direct;
        end
    end

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            a_reg      <= a_next;
            is_yuv_reg <= (fmt == FMT_YUV888);
        end
        if (b_ready && a_valid_reg) begin
            b_reg <= b_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_rgb_a = b_reg[0];
    assign out_rgb_b = b_reg[1];

endmodule

>>> rtl/core/pcc_rgb2yuv.sv
module pcc_rgb2yuv #(
    parameter int COEF_FRACTION_BITS = 12
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  pcc_pkg::rgb_t  in_rgb_a,
    input  pcc_pkg::rgb_t  in_rgb_b,
    output logic           out_valid,
    input  logic           out_ready,
    output pcc_pkg::info_t out_info,
    output pcc_pkg::yuv_t  out_yuv_b
);
    import pcc_pkg::*;

    localparam int F     = COEF_FRACTION_BITS;
    localparam int ONE   = 1 << F;
    localparam int KW    = F + 2;
    localparam int ACC_W = F + 11;

    localparam logic signed [KW-1:0] K_YR = KW'((299 * ONE + 500) / 1000);
    localparam logic signed [KW-1:0] K_YG = KW'((587 * ONE + 500) / 1000);
    localparam logic signed [KW-1:0] K_YB = KW'((114 * ONE + 500) / 1000);
    localparam logic signed [KW-1:0] K_UR = KW'((169 * ONE + 500) / 1000);
    localparam logic signed [KW-1:0] K_UG = KW'((332 * ONE + 500) / 1000);
    localparam logic signed [KW-1:0] K_UB = KW'((500 * ONE + 500) / 1000);
    localparam logic signed [KW-1:0] K_VR = KW'((500 * ONE + 500) / 1000);
    localparam logic signed [KW-1:0] K_VG = KW'((419 * ONE + 500) / 1000);
    localparam logic signed [KW-1:0] K_VB = KW'((813 * ONE + 5000) / 10000);
    localparam logic signed [ACC_W-1:0] OFF = ACC_W'(128 * ONE);

    typedef struct packed {
        logic signed [ACC_W-1:0] yr, yg, yb;
        logic signed [ACC_W-1:0] ur, ug, ub;
        logic signed [ACC_W-1:0] vr, vg, vb;
    } prod_t;

    prod_t c_next [2];
    prod_t c_reg  [2];
    rgb_t  c_rgb_reg;
    logic  c_same_reg;
    yuv_t  d_next [2];
    yuv_t  d_yuv_reg [2];
    rgb_t  d_rgb_reg;
    logic  d_same_reg;
    logic  c_valid_reg, d_valid_reg;
    logic  c_ready, d_ready;

    function automatic logic signed [ACC_W-1:0] mul(input logic signed [KW-1:0] k,
                                                    input logic [7:0] x);
        return ACC_W'(k) * $signed({{(ACC_W-8){1'b0}}, x});
    endfunction

    function automatic prod_t front(input rgb_t c);
        prod_t p;
        p.yr = mul(K_YR, c.r);
        p.yg = mul(K_YG, c.g);
        p.yb = mul(K_YB, c.b);
        p.ur = mul(K_UR, c.r);
        p.ug = mul(K_UG, c.g);
        p.ub = mul(K_UB, c.b);
        p.vr = mul(K_VR, c.r);
        p.vg = mul(K_VG, c.g);
        p.vb = mul(K_VB, c.b);
        return p;
    endfunction

    function automatic yuv_t back(input prod_t p);
        yuv_t o;
        o.y = settle(32'(p.yr + p.yg + p.yb), F);
        o.u = settle(32'(p.ub - p.ur - p.ug + OFF), F);
        o.v = settle(32'(p.vr - p.vg - p.vb + OFF), F);
        return o;
    endfunction

    always_comb begin
        c_next[0] = front(in_rgb_a);
        c_next[1] = front(in_rgb_b);
        for (int i = 0; i < 2; i++) begin
            d_next[i] = back(c_reg[i]);
        end
    end

    assign d_ready  = !d_valid_reg || out_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign in_ready = c_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else begin
            if (c_ready) begin
                c_valid_reg <= in_valid;
            end
            if (d_ready) begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (c_ready && in_valid) begin
            c_reg      <= c_next;
            c_rgb_reg  <= in_rgb_a;
            c_same_reg <= (in_rgb_a == in_rgb_b);
        end
        if (d_ready && c_valid_reg) begin
            d_yuv_reg  <= d_next;
            d_rgb_reg  <= c_rgb_reg;
            d_same_reg <= c_same_reg;
        end
    end

    assign out_valid     = d_valid_reg;
    assign out_info.rgb  = d_rgb_reg;
    assign out_info.yuv  = d_yuv_reg[0];
    assign out_info.same = d_same_reg;
    assign out_yuv_b     = d_yuv_reg[1];

endmodule

>>> rtl/core/pcc_distance.sv
module pcc_distance (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  pcc_pkg::info_t               in_info,
    input  pcc_pkg::yuv_t                in_yuv_b,
    output logic                         out_valid,
    input  logic                         out_ready,
    output pcc_pkg::info_t               out_info,
    output logic [pcc_pkg::ROOT_W-1:0]   out_root
);
    import pcc_pkg::*;

    localparam int XW   = SQ_W + 1;
    localparam int LAST = ISQRT_STAGES - 1;

    logic [15:0]      sq_next [3];
    logic [15:0]      sq_reg  [3];
    info_t            e_info_reg;
    logic [SQ_W-1:0]  sum_reg;
    info_t            f_info_reg;
    logic             e_valid_reg, f_valid_reg;
    logic             e_ready, f_ready;

    logic [XW-1:0]    x_src    [ISQRT_STAGES];
    logic [XW-1:0]    r_src    [ISQRT_STAGES];
    info_t            info_src [ISQRT_STAGES];
    logic [ISQRT_STAGES-1:0] q_src_valid;
    logic [XW-1:0]    x_next   [ISQRT_STAGES];
    logic [XW-1:0]    r_next   [ISQRT_STAGES];
    logic [XW-1:0]    x_reg    [ISQRT_STAGES];
    logic [XW-1:0]    r_reg    [ISQRT_STAGES];
    info_t            info_reg [ISQRT_STAGES];
    logic [ISQRT_STAGES-1:0] q_valid_reg;
    logic [ISQRT_STAGES-1:0] q_ready;

    function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return {8'd0, d} * {8'd0, d};
    endfunction

    always_comb begin
        sq_next[0] = sq_diff(in_info.yuv.y, in_yuv_b.y);
        sq_next[1] = sq_diff(in_info.yuv.u, in_yuv_b.u);
        sq_next[2] = sq_diff(in_info.yuv.v, in_yuv_b.v);
    end

    for (genvar gs = 0; gs < ISQRT_STAGES; gs++) begin : g_src
        if (gs == 0) begin : g_first
            assign x_src[gs]       = XW'(sum_reg);
            assign r_src[gs]       = '0;
            assign info_src[gs]    = f_info_reg;
            assign q_src_valid[gs] = f_valid_reg;
        end else begin : g_next
            assign x_src[gs]       = x_reg[gs-1];
            assign r_src[gs]       = r_reg[gs-1];
            assign info_src[gs]    = info_reg[gs-1];
            assign q_src_valid[gs] = q_valid_reg[gs-1];
        end
        if (gs == LAST) begin : g_rdy_last
            assign q_ready[gs] = !q_valid_reg[gs] || out_ready;
        end else begin : g_rdy_mid
            assign q_ready[gs] = !q_valid_reg[gs] || q_ready[gs+1];
        end
    end

    // Each stage resolves ISQRT_STEPS bits of the root, most significant first.
    always_comb begin
        logic [XW-1:0] x;
        logic [XW-1:0] r;
        logic [XW-1:0] t;
        logic [XW-1:0] bitv;
        for (int s = 0; s < ISQRT_STAGES; s++) begin
            x = x_src[s];
            r = r_src[s];
            for (int j = 0; j < ISQRT_STEPS; j++) begin
                bitv = XW'(1) << (2 * (ROOT_W - 1 - (s * ISQRT_STEPS + j)));
                t    = r + bitv;
                if (x >= t) begin
                    x = x - t;
                    r = (r >> 1) + bitv;
                end else begin
                    r = r >> 1;
                end
            end
            x_next[s] = x;
            r_next[s] = r;
        end
    end

    assign f_ready  = !f_valid_reg || q_ready[0];
    assign e_ready  = !e_valid_reg || f_ready;
    assign in_ready = e_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            q_valid_reg <= '0;
        end else begin
            if (e_ready) begin
                e_valid_reg <= in_valid;
            end
            if (f_ready) begin
                f_valid_reg <= e_valid_reg;
            end
            for (int s = 0; s < ISQRT_STAGES; s++) begin
                if (q_ready[s]) begin
                    q_valid_reg[s] <= q_src_valid[s];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (e_ready && in_valid) begin
            sq_reg     <= sq_next;
            e_info_reg <= in_info;
        end
        if (f_ready && e_valid_reg) begin
            sum_reg    <= SQ_W'(sq_reg[0]) + SQ_W'(sq_reg[1]) + SQ_W'(sq_reg[2]);
            f_info_reg <= e_info_reg;
        end
        for (int s = 0; s < ISQRT_STAGES; s++) begin
            if (q_ready[s] && q_src_valid[s]) begin
                x_reg[s]    <= x_next[s];
                r_reg[s]    <= r_next[s];
                info_reg[s] <= info_src[s];
            end
        end
    end

    assign out_valid = q_valid_reg[LAST];
    assign out_info  = info_reg[LAST];
    assign out_root  = r_reg[LAST][ROOT_W-1:0];

endmodule

>>> rtl/core/pixel_color_convert_compare_unit.sv
// Pixel pair color converter and comparator.
//
// The slave channel carries one word per pixel pair: three bytes of pixel A
// followed by three bytes of pixel B, in the format held by the source format
// register (RGB888, little-endian BGR555 or YUV888). The master channel
// returns one word per input word with the decoded RGB of pixel A, the YUV of
// that RGB, a flag set when both pixels decode to the same RGB, and the floor
// of the Euclidean distance between the two YUV triples.
// The source format is written through cfg_we and cfg_wdata; the user must
// write it only while no words are in flight, as the block does not enforce it.
// The datapath is a nine-stage pipeline: two decode stages, two RGB to YUV
// stages, one square stage, one sum stage and three square-root stages that
// each resolve three bits of the root. One word per cycle is sustained while
// the receiver does not stall.
// Every stage holds its own valid bit, so while the receiver stalls the
// pipeline keeps accepting words until every stage is full; no word is lost
// or repeated. Reset empties the pipeline and sets the format to RGB888.
module pixel_color_convert_compare_unit #(
    parameter int COEF_FRACTION_BITS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // first_byte_a, second_byte_a, third_byte_a, first_byte_b, second_byte_b,
    // third_byte_b, 8 bits each.
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // red, green, blue, luma, chroma_u, chroma_v (8 bits each), same_color (1),
    // yuv_distance (9), zero padding (6).
    output logic [63:0] m_tdata
);
    import pcc_pkg::*;

    fmt_t  source_format_reg;

    logic  dec_valid, dec_ready;
    rgb_t  dec_rgb_a, dec_rgb_b;
    logic  cvt_valid, cvt_ready;
    info_t cvt_info;
    yuv_t  cvt_yuv_b;
    info_t dst_info;
    logic [ROOT_W-1:0] dst_root;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_format_reg <= FMT_RGB888;
        end else if (cfg_we) begin
            source_format_reg <= fmt_t'(cfg_wdata);
        end
    end

    pcc_decode #(
        .COEF_FRACTION_BITS(COEF_FRACTION_BITS)
    ) u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fmt       (source_format_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pix_a  (pix_t'(s_tdata[23:0])),
        .in_pix_b  (pix_t'(s_tdata[47:24])),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .out_rgb_a (dec_rgb_a),
        .out_rgb_b (dec_rgb_b)
    );

    pcc_rgb2yuv #(
        .COEF_FRACTION_BITS(COEF_FRACTION_BITS)
    ) u_rgb2yuv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_rgb_a  (dec_rgb_a),
        .in_rgb_b  (dec_rgb_b),
        .out_valid (cvt_valid),
        .out_ready (cvt_ready),
        .out_info  (cvt_info),
        .out_yuv_b (cvt_yuv_b)
    );

    pcc_distance u_distance (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cvt_valid),
        .in_ready  (cvt_ready),
        .in_info   (cvt_info),
        .in_yuv_b  (cvt_yuv_b),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_info  (dst_info),
        .out_root  (dst_root)
    );

    assign m_tdata = {6'd0, dst_root, dst_info.same, dst_info.yuv, dst_info.rgb};

    a_same_zero_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[48] |-> m_tdata[57:49] == 9'd0)
        else $error("equal colors with nonzero distance");

    a_dist_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[57:49] <= 9'd441)
        else $error("distance out of range");

    a_ready_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without an output stall");

    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) && aresetn |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule
